@@ design/bccr_pkg.sv @@
// shared constants and codes for the baud change confirm/revert guard
package bccr_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_REQUEST = 2'd1;
	localparam logic [1:0] CMD_CONFIRM = 2'd2;
	localparam logic [1:0] CMD_TICK    = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_STATE = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ARMED = 2'd1;
	localparam logic [1:0] PH_WAIT  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_UART_CLK    = 3'd0;
	localparam logic [2:0] REG_BOOT_BAUD   = 3'd1;
	localparam logic [2:0] REG_DEFAULT     = 3'd2;
	localparam logic [2:0] REG_MAX_ERR_PPM = 3'd3;
	localparam logic [2:0] REG_CONFIRM_MS  = 3'd4;

	// reset values of the configuration registers
	localparam logic [31:0] RST_UART_CLK    = 32'd100000000;
	localparam logic [31:0] RST_BOOT_BAUD   = 32'd115200;
	localparam logic [31:0] RST_DEFAULT     = 32'd115200;
	localparam logic [31:0] RST_MAX_ERR_PPM = 32'd20000;
	localparam logic [15:0] RST_CONFIRM_MS  = 16'd3000;

	// divisor limits and error scale
	localparam logic [63:0] DIV_MIN   = 64'd16;
	localparam logic [63:0] DIV_MAX   = 64'd65535;
	localparam logic [31:0] PPM_SCALE = 32'd1000000;
	localparam logic [15:0] REM_SAT   = 16'hFFFF;

	// width of the shared divider
	localparam int DIV_W = 64;
	localparam int CNT_W = $clog2(DIV_W);

endpackage

@@ design/baud_change_confirm_revert.sv @@
// top level of the baud change confirm/revert guard with its serial divider
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ----------------------------
//  command   cmd baud_value table_present table_baud start high, busy low
//            now_ms
//  result    status active_baud confirmed_baud       done strobe, one cycle,
//            pending_baud phase apply_now            no back-pressure
//            table_writeback remaining_ms
//            applied_count commit_count reverted_count
//  config    cfg_we cfg_idx cfg_wdata                cfg_we, taken every edge
//
// a word that needs a reachability check (load, request in idle phase, tick in idle
// phase with a present, differing table rate) runs two 64-step divider passes plus
// multiply and compare steps before done; a divisor out of range skips the second
// pass. other words skip the divider and go straight to the done state.
// busy is high from accept until the cycle in which done is shown.
// arst_n clears the sequencer and all rate state to reset values at once.
module baud_change_confirm_revert (
	input  logic        clk,
	input  logic        arst_n,
	// command word
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] baud_value,
	input  logic        table_present,
	input  logic [31:0] table_baud,
	input  logic [47:0] now_ms,
	// result word
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] active_baud,
	output logic [31:0] confirmed_baud,
	output logic [31:0] pending_baud,
	output logic [1:0]  phase,
	output logic        apply_now,
	output logic        table_writeback,
	output logic [15:0] remaining_ms,
	output logic [31:0] applied_count,
	output logic [31:0] commit_count,
	output logic [31:0] reverted_count,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int DW = bccr_pkg::DIV_W;
	localparam int CW = bccr_pkg::CNT_W;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DIV1  = 9'b000000010,
		ST_RANGE = 9'b000000100,
		ST_MUL1  = 9'b000001000,
		ST_DIFF  = 9'b000010000,
		ST_MUL2  = 9'b000100000,
		ST_DIV2  = 9'b001000000,
		ST_EVAL  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t st_q;
	logic   out_st_q;

	// configuration registers
	logic [31:0] uart_clk_q, boot_baud_q, default_baud_q, max_err_q;
	logic [15:0] confirm_ms_q;

	// latched command word
	logic [1:0]  cmd_q;
	logic [31:0] baud_q, tbaud_q, chk_baud_q;
	logic        present_q;
	logic [47:0] now_q;

	// rate state
	logic [1:0]  phase_q;
	logic [31:0] active_q, committed_q, waiting_q;
	logic [48:0] deadline_q;
	logic [31:0] apply_cnt_q, confirm_cnt_q, revert_cnt_q;

	// datapath registers
	logic [DW-1:0] rem_q, quo_q, den_q, prod_q;
	logic [CW-1:0] cnt_q;
	logic [47:0]   got_q;
	logic [31:0]   diff_q;
	logic          reach_q;

	// result registers
	logic        done_q, apply_q, wb_q;
	logic [1:0]  status_q;
	logic [15:0] remain_q;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uart_clk_q     <= bccr_pkg::RST_UART_CLK;
			boot_baud_q    <= bccr_pkg::RST_BOOT_BAUD;
			default_baud_q <= bccr_pkg::RST_DEFAULT;
			max_err_q      <= bccr_pkg::RST_MAX_ERR_PPM;
			confirm_ms_q   <= bccr_pkg::RST_CONFIRM_MS;
		end else if (cfg_we) begin
			case (cfg_idx)
				bccr_pkg::REG_UART_CLK:    uart_clk_q     <= cfg_wdata;
				bccr_pkg::REG_BOOT_BAUD:   boot_baud_q    <= cfg_wdata;
				bccr_pkg::REG_DEFAULT:     default_baud_q <= cfg_wdata;
				bccr_pkg::REG_MAX_ERR_PPM: max_err_q      <= cfg_wdata;
				bccr_pkg::REG_CONFIRM_MS:  confirm_ms_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// accept decode: which rate needs a reachability check
	logic        accept;
	logic        need_chk;
	logic [31:0] sel_baud;
	logic [32:0] num_init;

	assign accept = start && (st_q == ST_IDLE) && !out_st_q;

	always_comb begin
		need_chk = 1'b0;
		sel_baud = baud_value;
		case (cmd)
			bccr_pkg::CMD_LOAD: begin
				need_chk = 1'b1;
				sel_baud = boot_baud_q;
			end
			bccr_pkg::CMD_REQUEST: begin
				need_chk = (phase_q == bccr_pkg::PH_IDLE);
			end
			bccr_pkg::CMD_TICK: begin
				need_chk = table_present && (phase_q == bccr_pkg::PH_IDLE) &&
					(table_baud != active_q);
				sel_baud = table_baud;
			end
			default: need_chk = 1'b0;
		endcase
	end

	// rounded divisor numerator: uart clock + baud/2
	assign num_init = {1'b0, uart_clk_q} + {2'b00, sel_baud[31:1]};

	// restoring divider step, one quotient bit per cycle
	logic [DW:0]   div_r, div_sub;
	logic          div_ge;
	logic [DW-1:0] rem_nx, quo_nx;

	assign div_r   = {rem_q, quo_q[DW-1]};
	assign div_sub = div_r - {1'b0, den_q};
	assign div_ge  = (div_r >= {1'b0, den_q});
	assign rem_nx  = div_ge ? div_sub[DW-1:0] : div_r[DW-1:0];
	assign quo_nx  = {quo_q[DW-2:0], div_ge};

	// shared multiplier operands
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	always_comb begin
		if (st_q == ST_MUL2) begin
			mul_a = diff_q;
			mul_b = bccr_pkg::PPM_SCALE;
		end else begin
			mul_a = chk_baud_q;
			mul_b = {16'h0000, quo_q[15:0]};
		end
	end
	assign mul_p = {32'h0, mul_a} * {32'h0, mul_b};

	// absolute rate error |uart clock - baud * divisor|, at most baud/2
	logic [47:0] kern48, diff48;
	assign kern48 = {16'h0000, uart_clk_q};
	assign diff48 = (kern48 > prod_q[47:0]) ? (kern48 - prod_q[47:0]) :
		(prod_q[47:0] - kern48);

	// command outcome on the rate state
	logic [1:0]  phase_d, status_d;
	logic [31:0] active_d, committed_d, waiting_d, boot_sel;
	logic [48:0] deadline_d, deadline_new;
	logic [31:0] apply_cnt_d, confirm_cnt_d, revert_cnt_d;
	logic        apply_d, wb_d, applied, expired;

	assign boot_sel     = reach_q ? boot_baud_q : default_baud_q;
	assign deadline_new = {1'b0, now_q} + {33'h0, confirm_ms_q};

	always_comb begin
		phase_d       = phase_q;
		active_d      = active_q;
		committed_d   = committed_q;
		waiting_d     = waiting_q;
		deadline_d    = deadline_q;
		apply_cnt_d   = apply_cnt_q;
		confirm_cnt_d = confirm_cnt_q;
		revert_cnt_d  = revert_cnt_q;
		status_d      = bccr_pkg::STAT_OK;
		apply_d       = 1'b0;
		wb_d          = 1'b0;
		applied       = 1'b0;
		expired       = 1'b0;
		case (cmd_q)
			bccr_pkg::CMD_LOAD: begin
				active_d      = boot_sel;
				committed_d   = boot_sel;
				waiting_d     = 32'h0;
				deadline_d    = 49'h0;
				phase_d       = bccr_pkg::PH_IDLE;
				apply_cnt_d   = 32'h0;
				confirm_cnt_d = 32'h0;
				revert_cnt_d  = 32'h0;
			end
			bccr_pkg::CMD_REQUEST: begin
				if (phase_q != bccr_pkg::PH_IDLE) begin
					status_d = bccr_pkg::STAT_STATE;
				end else if (!reach_q) begin
					status_d = bccr_pkg::STAT_RANGE;
				end else if (baud_q != active_q) begin
					waiting_d = baud_q;
					phase_d   = bccr_pkg::PH_ARMED;
				end
			end
			bccr_pkg::CMD_CONFIRM: begin
				if (phase_q != bccr_pkg::PH_WAIT) begin
					status_d = bccr_pkg::STAT_STATE;
				end else if (baud_q != waiting_q) begin
					status_d = bccr_pkg::STAT_RANGE;
				end else begin
					committed_d   = waiting_q;
					waiting_d     = 32'h0;
					phase_d       = bccr_pkg::PH_IDLE;
					confirm_cnt_d = confirm_cnt_q + 32'd1;
				end
			end
			default: begin
				// tick: table rate as an implicit request
				if (present_q && (phase_q == bccr_pkg::PH_IDLE) &&
						(tbaud_q != active_q) && reach_q) begin
					waiting_d = tbaud_q;
					phase_d   = bccr_pkg::PH_ARMED;
				end
				// apply an armed rate
				if (phase_d == bccr_pkg::PH_ARMED) begin
					applied     = 1'b1;
					active_d    = waiting_d;
					phase_d     = bccr_pkg::PH_WAIT;
					deadline_d  = deadline_new;
					apply_cnt_d = apply_cnt_q + 32'd1;
				end
				// deadline passed: fresh deadline expires only with a zero window
				if (applied) begin
					expired = (confirm_ms_q == 16'h0);
				end else begin
					expired = (phase_q == bccr_pkg::PH_WAIT) &&
						({1'b0, now_q} >= deadline_q);
				end
				if (expired) begin
					active_d     = committed_q;
					waiting_d    = 32'h0;
					phase_d      = bccr_pkg::PH_IDLE;
					revert_cnt_d = revert_cnt_q + 32'd1;
				end
				apply_d = applied || expired;
				wb_d    = present_q;
			end
		endcase
	end

	// time left before revert, saturated
	logic [48:0] left49;
	logic [15:0] remain_d;
	assign left49 = deadline_q - {1'b0, now_q};
	always_comb begin
		remain_d = 16'h0;
		if ((phase_q == bccr_pkg::PH_WAIT) && (deadline_q > {1'b0, now_q})) begin
			remain_d = (left49[48:16] != 33'h0) ? bccr_pkg::REM_SAT : left49[15:0];
		end
	end

	// sequencer and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			out_st_q      <= 1'b0;
			done_q        <= 1'b0;
			phase_q       <= bccr_pkg::PH_IDLE;
			active_q      <= bccr_pkg::RST_DEFAULT;
			committed_q   <= bccr_pkg::RST_DEFAULT;
			waiting_q     <= 32'h0;
			deadline_q    <= 49'h0;
			apply_cnt_q   <= 32'h0;
			confirm_cnt_q <= 32'h0;
			revert_cnt_q  <= 32'h0;
			reach_q       <= 1'b0;
		end else begin
			done_q   <= out_st_q;
			out_st_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						reach_q <= 1'b0;
						st_q    <= need_chk ? ST_DIV1 : ST_DONE;
					end
				end
				ST_DIV1: begin
					if (cnt_q == '0) begin
						st_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					if ((quo_q >= bccr_pkg::DIV_MIN) && (quo_q <= bccr_pkg::DIV_MAX)) begin
						st_q <= ST_MUL1;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_MUL1: st_q <= ST_DIFF;
				ST_DIFF: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_DIV2;
				ST_DIV2: begin
					if (cnt_q == '0) begin
						st_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					reach_q <= (quo_q[31:0] <= max_err_q);
					st_q    <= ST_DONE;
				end
				ST_DONE: begin
					phase_q       <= phase_d;
					active_q      <= active_d;
					committed_q   <= committed_d;
					waiting_q     <= waiting_d;
					deadline_q    <= deadline_d;
					apply_cnt_q   <= apply_cnt_d;
					confirm_cnt_q <= confirm_cnt_d;
					revert_cnt_q  <= revert_cnt_d;
					out_st_q      <= 1'b1;
					st_q          <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: latched word, divider, multiplier results
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q      <= cmd;
					baud_q     <= baud_value;
					present_q  <= table_present;
					tbaud_q    <= table_baud;
					now_q      <= now_ms;
					chk_baud_q <= sel_baud;
					rem_q      <= '0;
					quo_q      <= {{(DW - 33){1'b0}}, num_init};
					den_q      <= {{(DW - 32){1'b0}}, sel_baud};
					cnt_q      <= CW'(DW - 1);
				end
			end
			ST_DIV1, ST_DIV2: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL1: prod_q <= mul_p;
			ST_DIFF: begin
				got_q  <= prod_q[47:0];
				diff_q <= diff48[31:0];
			end
			ST_MUL2: begin
				// error times ppm over baud * divisor
				rem_q <= '0;
				quo_q <= mul_p;
				den_q <= {{(DW - 48){1'b0}}, got_q};
				cnt_q <= CW'(DW - 1);
			end
			ST_DONE: begin
				status_q <= status_d;
				apply_q  <= apply_d;
				wb_q     <= wb_d;
			end
			default: ;
		endcase
		if (out_st_q) begin
			remain_q <= remain_d;
		end
	end

	// result ports
	assign busy            = (st_q != ST_IDLE) || out_st_q;
	assign done            = done_q;
	assign status          = status_q;
	assign active_baud     = active_q;
	assign confirmed_baud  = committed_q;
	assign pending_baud    = waiting_q;
	assign phase           = phase_q;
	assign apply_now       = apply_q;
	assign table_writeback = wb_q;
	assign remaining_ms    = remain_q;
	assign applied_count   = apply_cnt_q;
	assign commit_count    = confirm_cnt_q;
	assign reverted_count  = revert_cnt_q;

endmodule

@@ tb/sv/baud_change_confirm_revert_test.sv @@
// self-checking testbench for the baud change confirm/revert guard
`timescale 1ns / 100ps

module baud_change_confirm_revert_test;
	import bccr_pkg::*;

	// one result word as the block reports it
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] active;
		logic [31:0] committed;
		logic [31:0] waiting;
		logic [1:0]  phase;
		logic        apply_now;
		logic        writeback;
		logic [15:0] remaining;
		logic [31:0] applied;
		logic [31:0] confirmed;
		logic [31:0] reverted;
	} guard_reply_t;

	// one row of the directed table; status and phase typed in by hand
	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] rate;
		logic        tp;
		logic [31:0] trate;
		logic [47:0] now;
		logic [1:0]  st;
		logic [1:0]  ph;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [31:0] baud_value;
	logic        table_present;
	logic [31:0] table_baud;
	logic [47:0] now_ms;
	logic        done;
	logic [1:0]  status;
	logic [31:0] active_baud;
	logic [31:0] confirmed_baud;
	logic [31:0] pending_baud;
	logic [1:0]  phase;
	logic        apply_now;
	logic        table_writeback;
	logic [15:0] remaining_ms;
	logic [31:0] applied_count;
	logic [31:0] commit_count;
	logic [31:0] reverted_count;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	// mirror of the configuration registers
	logic [31:0] kern_hz;
	logic [31:0] boot_rate;
	logic [31:0] fallback_rate;
	logic [31:0] err_limit;
	logic [15:0] window_ms;

	// mirror of the rate guard state
	logic [1:0]  cur_phase;
	logic [31:0] cur_active;
	logic [31:0] cur_committed;
	logic [31:0] cur_waiting;
	logic [48:0] cur_deadline;
	logic [31:0] n_applied;
	logic [31:0] n_confirmed;
	logic [31:0] n_reverted;

	guard_reply_t predicted_replies [$];
	stim_row_t    directed_rows [$];
	int           mismatches = 0;
	int           replies_seen = 0;
	bit           no_gaps = 1'b0;
	logic [47:0]  wall_ms = 48'd0;

	baud_change_confirm_revert uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd), .baud_value(baud_value),
		.table_present(table_present), .table_baud(table_baud), .now_ms(now_ms),
		.done(done), .status(status), .active_baud(active_baud),
		.confirmed_baud(confirmed_baud), .pending_baud(pending_baud), .phase(phase),
		.apply_now(apply_now), .table_writeback(table_writeback),
		.remaining_ms(remaining_ms), .applied_count(applied_count),
		.commit_count(commit_count), .reverted_count(reverted_count),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// uart divisor with rounding, 0 for a zero rate
	function automatic logic [63:0] divisor_for(input logic [31:0] rate);
		if (rate == 32'd0)
			return 64'd0;
		return ({32'd0, kern_hz} + {32'd0, rate >> 1}) / {32'd0, rate};
	endfunction

	// rate error in ppm for a given divisor
	function automatic logic [31:0] error_ppm_of(input logic [31:0] rate, input logic [63:0] dv);
		logic [63:0] got;
		logic [63:0] diff;
		if (dv == 64'd0 || rate == 32'd0)
			return 32'hFFFF_FFFF;
		got = {32'd0, rate} * dv;
		diff = ({32'd0, kern_hz} > got) ? {32'd0, kern_hz} - got : got - {32'd0, kern_hz};
		return 32'((diff * {32'd0, PPM_SCALE}) / got);
	endfunction

	function automatic bit rate_reachable(input logic [31:0] rate);
		logic [63:0] dv;
		dv = divisor_for(rate);
		if (dv < DIV_MIN || dv > DIV_MAX)
			return 1'b0;
		return error_ppm_of(rate, dv) <= err_limit;
	endfunction

	// a rate change asked for by the host or by the settings table
	task automatic try_rate_change(input logic [31:0] rate, output logic [1:0] st);
		if (cur_phase != PH_IDLE) begin
			st = STAT_STATE;
		end else if (!rate_reachable(rate)) begin
			st = STAT_RANGE;
		end else begin
			st = STAT_OK;
			if (rate != cur_active) begin
				cur_waiting = rate;
				cur_phase = PH_ARMED;
			end
		end
	endtask

	// advance the mirrored guard by one command word and form its result
	task automatic predict_reply(input logic [1:0] c, input logic [31:0] rate, input logic tp,
			input logic [31:0] trate, input logic [47:0] t, output guard_reply_t w);
		logic [1:0]  st;
		logic [1:0]  dropped;
		logic        applied;
		logic [48:0] now49;
		logic [48:0] left;
		logic [31:0] pick;
		st = STAT_OK;
		applied = 1'b0;
		now49 = {1'b0, t};
		case (c)
			CMD_LOAD: begin
				pick = rate_reachable(boot_rate) ? boot_rate : fallback_rate;
				cur_active = pick;
				cur_committed = pick;
				cur_waiting = 32'd0;
				cur_deadline = 49'd0;
				cur_phase = PH_IDLE;
				n_applied = 32'd0;
				n_confirmed = 32'd0;
				n_reverted = 32'd0;
			end
			CMD_REQUEST: begin
				try_rate_change(rate, st);
			end
			CMD_CONFIRM: begin
				if (cur_phase != PH_WAIT) begin
					st = STAT_STATE;
				end else if (rate != cur_waiting) begin
					st = STAT_RANGE;
				end else begin
					cur_committed = cur_waiting;
					cur_waiting = 32'd0;
					cur_phase = PH_IDLE;
					n_confirmed = n_confirmed + 32'd1;
				end
			end
			CMD_TICK: begin
				// a differing table value acts as a request, outcome dropped
				if (tp && cur_phase == PH_IDLE && trate != cur_active)
					try_rate_change(trate, dropped);
				if (cur_phase == PH_ARMED) begin
					cur_active = cur_waiting;
					cur_phase = PH_WAIT;
					cur_deadline = now49 + {33'd0, window_ms};
					n_applied = n_applied + 32'd1;
					applied = 1'b1;
				end
				if (cur_phase == PH_WAIT && now49 >= cur_deadline) begin
					cur_active = cur_committed;
					cur_waiting = 32'd0;
					cur_phase = PH_IDLE;
					n_reverted = n_reverted + 32'd1;
					applied = 1'b1;
				end
			end
			default: ;
		endcase
		w.status = st;
		w.active = cur_active;
		w.committed = cur_committed;
		w.waiting = cur_waiting;
		w.phase = cur_phase;
		w.apply_now = applied;
		w.writeback = (c == CMD_TICK) && tp;
		w.remaining = 16'd0;
		if (cur_phase == PH_WAIT && cur_deadline > now49) begin
			left = cur_deadline - now49;
			w.remaining = (left > {33'd0, REM_SAT}) ? REM_SAT : left[15:0];
		end
		w.applied = n_applied;
		w.confirmed = n_confirmed;
		w.reverted = n_reverted;
	endtask

	// one line per mismatch
	task automatic log_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("word %0d %s got %0h expected %0h",
				replies_seen, name, got, want));
	endtask

	// compare every result word with the oldest prediction
	always @(posedge clk) begin : reply_check
		guard_reply_t w;
		if (arst_n && done) begin
			replies_seen++;
			if (predicted_replies.size() == 0) begin
				log_mismatch($sformatf("word %0d arrived with nothing expected", replies_seen));
			end else begin
				w = predicted_replies.pop_front();
				check_field("status", status, w.status);
				check_field("active_baud", active_baud, w.active);
				check_field("confirmed_baud", confirmed_baud, w.committed);
				check_field("pending_baud", pending_baud, w.waiting);
				check_field("phase", phase, w.phase);
				check_field("apply_now", apply_now, w.apply_now);
				check_field("table_writeback", table_writeback, w.writeback);
				check_field("remaining_ms", remaining_ms, w.remaining);
				check_field("applied_count", applied_count, w.applied);
				check_field("commit_count", commit_count, w.confirmed);
				check_field("reverted_count", reverted_count, w.reverted);
			end
		end
	end

	// send one command word, then record what it should produce
	task automatic issue_word(input logic [1:0] c, input logic [31:0] rate, input logic tp,
			input logic [31:0] trate, input logic [47:0] t, input bit typed,
			input logic [1:0] want_st, input logic [1:0] want_ph);
		int gap;
		guard_reply_t w;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		baud_value <= rate;
		table_present <= tp;
		table_baud <= trate;
		now_ms <= t;
		do @(posedge clk); while (busy);
		predict_reply(c, rate, tp, trate, t, w);
		if (typed) begin
			w.status = want_st;
			w.phase = want_ph;
		end
		predicted_replies.push_back(w);
	endtask

	task automatic add_row(input logic [1:0] c, input logic [31:0] rate, input logic tp,
			input logic [31:0] trate, input logic [47:0] t, input logic [1:0] st,
			input logic [1:0] ph);
		stim_row_t r;
		r.cmd = c;
		r.rate = rate;
		r.tp = tp;
		r.trate = trate;
		r.now = t;
		r.st = st;
		r.ph = ph;
		directed_rows.push_back(r);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_UART_CLK:    kern_hz = val;
			REG_BOOT_BAUD:   boot_rate = val;
			REG_DEFAULT:     fallback_rate = val;
			REG_MAX_ERR_PPM: err_limit = val;
			REG_CONFIRM_MS:  window_ms = val[15:0];
			default: ;
		endcase
	endtask

	// let the block drain, then rewrite all registers
	task automatic program_regs(input logic [31:0] k, input logic [31:0] b, input logic [31:0] d,
			input logic [31:0] e, input logic [31:0] cw);
		start <= 1'b0;
		while (predicted_replies.size() != 0) @(posedge clk);
		@(posedge clk);
		set_reg(REG_UART_CLK, k);
		set_reg(REG_BOOT_BAUD, b);
		set_reg(REG_DEFAULT, d);
		set_reg(REG_MAX_ERR_PPM, e);
		set_reg(REG_CONFIRM_MS, cw);
		cfg_we <= 1'b0;
	endtask

	// a rate that is likely reachable under the current kernel clock
	function automatic logic [31:0] pick_rate();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 5) begin
			case ($urandom_range(0, 9))
				0: return 32'd1200;
				1: return 32'd4800;
				2: return 32'd9600;
				3: return 32'd19200;
				4: return 32'd38400;
				5: return 32'd57600;
				6: return 32'd115200;
				7: return 32'd230400;
				8: return 32'd921600;
				default: return 32'd3000000;
			endcase
		end
		if (k < 8)
			return kern_hz / $urandom_range(16, 65535);
		if (k == 8)
			return $urandom_range(0, 1) ? kern_hz >> 4 : kern_hz / 65535;
		return $urandom;
	endfunction

	// one random word, biased toward complete request/apply/confirm cycles
	task automatic random_word();
		int unsigned r;
		int unsigned s;
		logic [1:0]  c;
		logic [31:0] rate;
		logic [31:0] trate;
		logic        tp;
		r = $urandom_range(0, 99);
		if (r < 4)
			c = CMD_LOAD;
		else if (r < 34)
			c = CMD_REQUEST;
		else if (r < 58)
			c = CMD_CONFIRM;
		else
			c = CMD_TICK;
		s = $urandom_range(0, 9);
		if (cur_phase == PH_WAIT && s < 7)
			rate = cur_waiting;
		else if (s == 8)
			rate = cur_active;
		else if (s == 9)
			rate = $urandom;
		else
			rate = pick_rate();
		tp = $urandom_range(0, 1);
		s = $urandom_range(0, 9);
		if (s < 4)
			trate = pick_rate();
		else if (s < 7)
			trate = cur_active;
		else
			trate = $urandom;
		// move the millisecond clock, mostly in small steps
		s = $urandom_range(0, 99);
		if (s < 75)
			wall_ms = wall_ms + 48'($urandom_range(0, 1500));
		else if (s < 93)
			wall_ms = wall_ms + 48'($urandom_range(0, 70000));
		else if (s < 97)
			wall_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4000));
		else
			wall_ms = {16'($urandom), 32'($urandom)};
		issue_word(c, rate, tp, trate, wall_ms, 1'b0, STAT_OK, PH_IDLE);
	endtask

	initial begin : stimulus
		stim_row_t row;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_LOAD;
		baud_value <= 32'd0;
		table_present <= 1'b0;
		table_baud <= 32'd0;
		now_ms <= 48'd0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_UART_CLK;
		cfg_wdata <= 32'd0;

		// state after reset
		kern_hz = RST_UART_CLK;
		boot_rate = RST_BOOT_BAUD;
		fallback_rate = RST_DEFAULT;
		err_limit = RST_MAX_ERR_PPM;
		window_ms = RST_CONFIRM_MS;
		cur_phase = PH_IDLE;
		cur_active = RST_DEFAULT;
		cur_committed = RST_DEFAULT;
		cur_waiting = 32'd0;
		cur_deadline = 49'd0;
		n_applied = 32'd0;
		n_confirmed = 32'd0;
		n_reverted = 32'd0;

		// directed walk at reset settings: refusals, apply, confirm, revert, edges
		add_row(CMD_LOAD,    32'd0,         1'b0, 32'd0,         48'd0,    STAT_OK,    PH_IDLE);
		add_row(CMD_REQUEST, 32'd0,         1'b0, 32'd0,         48'd0,    STAT_RANGE, PH_IDLE);
		add_row(CMD_REQUEST, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 48'd0,    STAT_RANGE, PH_IDLE);
		add_row(CMD_REQUEST, 32'd115200,    1'b0, 32'd0,         48'd10,   STAT_OK,    PH_IDLE);
		add_row(CMD_CONFIRM, 32'd9600,      1'b0, 32'd0,         48'd20,   STAT_STATE, PH_IDLE);
		add_row(CMD_REQUEST, 32'd1525,      1'b0, 32'd0,         48'd30,   STAT_RANGE, PH_IDLE);
		add_row(CMD_REQUEST, 32'd9600,      1'b0, 32'd0,         48'd40,   STAT_OK,    PH_ARMED);
		add_row(CMD_REQUEST, 32'd19200,     1'b0, 32'd0,         48'd50,   STAT_STATE, PH_ARMED);
		add_row(CMD_CONFIRM, 32'd9600,      1'b0, 32'd0,         48'd60,   STAT_STATE, PH_ARMED);
		add_row(CMD_TICK,    32'd0,         1'b0, 32'd0,         48'd1000, STAT_OK,    PH_WAIT);
		add_row(CMD_REQUEST, 32'd19200,     1'b0, 32'd0,         48'd1500, STAT_STATE, PH_WAIT);
		add_row(CMD_CONFIRM, 32'd19200,     1'b0, 32'd0,         48'd1600, STAT_RANGE, PH_WAIT);
		add_row(CMD_TICK,    32'd0,         1'b1, 32'd4800,      48'd2000, STAT_OK,    PH_WAIT);
		add_row(CMD_CONFIRM, 32'd9600,      1'b0, 32'd0,         48'd2500, STAT_OK,    PH_IDLE);
		add_row(CMD_TICK,    32'd0,         1'b1, 32'd57600,     48'd5000, STAT_OK,    PH_WAIT);
		add_row(CMD_TICK,    32'd0,         1'b0, 32'd0,         48'd8000, STAT_OK,    PH_IDLE);
		add_row(CMD_TICK,    32'd0,         1'b1, 32'd9600,      48'd9000, STAT_OK,    PH_IDLE);
		add_row(CMD_TICK,    32'd0,         1'b1, 32'd0,         48'd9500, STAT_OK,    PH_IDLE);
		add_row(CMD_REQUEST, 32'd6250000,   1'b0, 32'd0,         48'd9600, STAT_OK,    PH_ARMED);
		add_row(CMD_TICK,    32'd0,         1'b0, 32'd0, 48'hFFFF_FFFF_FFFF, STAT_OK,  PH_WAIT);
		add_row(CMD_TICK,    32'd0,         1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, STAT_OK, PH_WAIT);
		add_row(CMD_CONFIRM, 32'd6250000,   1'b0, 32'd0,         48'd0,    STAT_OK,    PH_IDLE);
		add_row(CMD_REQUEST, 32'd1526,      1'b0, 32'd0,         48'd0,    STAT_OK,    PH_ARMED);
		add_row(CMD_TICK,    32'd0,         1'b0, 32'd0,         48'd0,    STAT_OK,    PH_WAIT);
		add_row(CMD_TICK,    32'd0,         1'b0, 32'd0,         48'd3000, STAT_OK,    PH_IDLE);
		add_row(CMD_LOAD,    32'd0,         1'b1, 32'd0,         48'd3000, STAT_OK,    PH_IDLE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			issue_word(row.cmd, row.rate, row.tp, row.trate, row.now, 1'b1, row.st, row.ph);
		end

		// random phases, each under its own register settings
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: ;
				1: program_regs(32'd48000000, 32'd9600, 32'd115200, 32'd20000, 32'd1);
				2: program_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
				3: program_regs(32'd0, $urandom, 32'd1, 32'd0, 32'd0);
				4: program_regs(32'd100000000, 32'd3000000, 32'd9600, 32'd5000, 32'd50);
				default: program_regs($urandom_range(1000000, 200000000),
					$urandom_range(300, 4000000), $urandom_range(1, 4000000),
					$urandom_range(0, 50000), {16'($urandom), 16'($urandom_range(1, 8000))});
			endcase
			if (p > 0)
				issue_word(CMD_LOAD, $urandom, 1'b0, $urandom, wall_ms, 1'b0, STAT_OK, PH_IDLE);
			for (int i = 0; i < 100; i++) begin
				if (i % 40 == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				random_word();
			end
		end

		start <= 1'b0;
		while (predicted_replies.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
